// ===== rtl/ecpmc_pkg.sv =====
`default_nettype none

package ecpmc_pkg;

    // Field widths of the request and result items
    localparam int MOTOR_W    = 2;
    localparam int COUNT_W    = 16;
    localparam int CUR_W      = 16;
    localparam int MODE_W     = 2;
    localparam int TGT_W      = 32;
    localparam int DRIVE_W    = 16;
    localparam int SPEED_W    = 17;
    localparam int POS_W      = 32;

    // Configuration
    localparam int GAIN_W     = 24;
    localparam int LIM_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [LIM_W-1:0] SPEED_LIMIT_RST = 15'd10000;

    // Datapath widths
    localparam int INTEG_W    = 32;
    localparam int ERR_W      = 34;   // Q16.16 error plus headroom
    localparam int PROD_W     = 59;   // ERR_W x (GAIN_W + sign)
    localparam int DIFF_W     = 18;   // raw count difference
    localparam int FRAC_W     = 16;   // Q16.16 fraction bits
    localparam int TQ_SHIFT   = 8;    // Q8.8 current times Q8.16 kt to Q16.16
    localparam int TQ_OUT_SHIFT = 32; // torque error times kp to duty

    localparam int MOTORS_DEF = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF      = 2'd0,
        MODE_TORQUE   = 2'd1,
        MODE_SPEED    = 2'd2,
        MODE_POSITION = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_KP    = 3'd0,
        REG_SPEED_KI_DT = 3'd1,
        REG_SPEED_LIMIT = 3'd2,
        REG_POS_KP      = 3'd3,
        REG_POS_KI_DT   = 3'd4,
        REG_POS_LIMIT   = 3'd5,
        REG_TORQUE_KP   = 3'd6,
        REG_TORQUE_KT   = 3'd7
    } t_cfg_reg;

    // Operand pair of the shared multiplier
    typedef enum logic [2:0] {
        MUL_CUR_KT  = 3'd0,
        MUL_ERR_TKP = 3'd1,
        MUL_ERR_PKI = 3'd2,
        MUL_ERR_PKP = 3'd3,
        MUL_ERR_SKI = 3'd4,
        MUL_ERR_SKP = 3'd5
    } t_mul_sel;

    typedef struct packed {
        logic     capture;
        logic     unwrap;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     t_err;
        logic     t_sat;
        logic     p_err;
        logic     p_integ;
        logic     p_cmd;
        logic     s_err;
        logic     s_integ;
        logic     s_out;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic  in_range;
        logic  enabled;
        t_mode mode;
    } t_dp_status;

    // Arithmetic shift right that truncates toward zero
    function automatic logic signed [PROD_W-1:0] shr_tz(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              n
    );
        logic signed [PROD_W-1:0] bias;
        bias = v[PROD_W-1] ? ((PROD_W'(1) <<< n) - PROD_W'(1)) : '0;
        return (v + bias) >>> n;
    endfunction

    // Clamp to +/- (lim << 16)
    function automatic logic signed [PROD_W-1:0] clamp_lim(
        input logic signed [PROD_W-1:0] v,
        input logic [LIM_W-1:0]         lim
    );
        logic signed [PROD_W-1:0] hi;
        hi = $signed(PROD_W'({lim, {FRAC_W{1'b0}}}));
        if (v > hi) begin
            return hi;
        end else if (v < -hi) begin
            return -hi;
        end
        return v;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(32767);
        lo = -PROD_W'(32768);
        if (v > hi) begin
            return DRIVE_W'(hi);
        end else if (v < lo) begin
            return DRIVE_W'(lo);
        end
        return DRIVE_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ecpmc_req_if.sv =====
`default_nettype none

interface ecpmc_req_if;
    logic                                      valid;
    logic                                      ready;
    logic        [ecpmc_pkg::MOTOR_W-1:0]      motor;
    logic signed [ecpmc_pkg::COUNT_W-1:0]      encoder_count;
    logic signed [ecpmc_pkg::CUR_W-1:0]        current_sample;
    logic                                      enabled;
    logic        [ecpmc_pkg::MODE_W-1:0]       mode;
    logic signed [ecpmc_pkg::TGT_W-1:0]        target;

    modport source (
        output valid, motor, encoder_count, current_sample, enabled, mode, target,
        input  ready
    );
    modport sink (
        input  valid, motor, encoder_count, current_sample, enabled, mode, target,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ecpmc_rsp_if.sv =====
`default_nettype none

interface ecpmc_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic        [ecpmc_pkg::MOTOR_W-1:0]      motor_out;
    logic signed [ecpmc_pkg::DRIVE_W-1:0]      drive;
    logic                                      drive_valid;
    logic signed [ecpmc_pkg::SPEED_W-1:0]      speed;
    logic signed [ecpmc_pkg::POS_W-1:0]        position;

    modport source (
        output valid, motor_out, drive, drive_valid, speed, position,
        input  ready
    );
    modport sink (
        input  valid, motor_out, drive, drive_valid, speed, position,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ecpmc_dp.sv =====
`default_nettype none

module ecpmc_dp #(
    parameter int MOTORS = ecpmc_pkg::MOTORS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [ecpmc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [ecpmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        [ecpmc_pkg::MOTOR_W-1:0]    i_motor,
    input  logic signed [ecpmc_pkg::COUNT_W-1:0]    i_encoder_count,
    input  logic signed [ecpmc_pkg::CUR_W-1:0]      i_current_sample,
    input  logic                                   i_enabled,
    input  logic        [ecpmc_pkg::MODE_W-1:0]     i_mode,
    input  logic signed [ecpmc_pkg::TGT_W-1:0]      i_target,
    input  ecpmc_pkg::t_dp_cmd                     i_cmd,
    output ecpmc_pkg::t_dp_status                  o_status,
    output logic        [ecpmc_pkg::MOTOR_W-1:0]    o_motor_out,
    output logic signed [ecpmc_pkg::DRIVE_W-1:0]    o_drive,
    output logic                                   o_drive_valid,
    output logic signed [ecpmc_pkg::SPEED_W-1:0]    o_speed,
    output logic signed [ecpmc_pkg::POS_W-1:0]      o_position
);

    localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int EXT_W = (IDX_W > ecpmc_pkg::MOTOR_W) ? IDX_W : ecpmc_pkg::MOTOR_W;
    localparam int PW    = ecpmc_pkg::PROD_W;
    localparam int EW    = ecpmc_pkg::ERR_W;
    localparam int DW    = ecpmc_pkg::DIFF_W;

    // Configuration registers
    logic [ecpmc_pkg::GAIN_W-1:0] r_speed_kp, r_speed_ki_dt, r_pos_kp, r_pos_ki_dt;
    logic [ecpmc_pkg::GAIN_W-1:0] r_torque_kp, r_torque_kt;
    logic [ecpmc_pkg::LIM_W-1:0]  r_speed_limit, r_pos_limit;

    // Per-motor state
    logic signed [ecpmc_pkg::COUNT_W-1:0] r_prev  [MOTORS];
    logic signed [ecpmc_pkg::POS_W-1:0]   r_tot   [MOTORS];
    logic signed [ecpmc_pkg::INTEG_W-1:0] r_s_int [MOTORS];
    logic signed [ecpmc_pkg::INTEG_W-1:0] r_p_int [MOTORS];

    // Working registers of the request in flight
    logic        [ecpmc_pkg::MOTOR_W-1:0] r_motor;
    logic signed [ecpmc_pkg::COUNT_W-1:0] r_cnt;
    logic signed [ecpmc_pkg::CUR_W-1:0]   r_cur;
    logic                                 r_en;
    ecpmc_pkg::t_mode                     r_mode;
    logic signed [ecpmc_pkg::TGT_W-1:0]   r_sp;      // target, then speed command
    logic signed [EW-1:0]                 r_err;
    logic signed [PW-1:0]                 r_prod;
    logic signed [ecpmc_pkg::SPEED_W-1:0] r_delta;
    logic signed [ecpmc_pkg::POS_W-1:0]   r_total;
    logic signed [ecpmc_pkg::DRIVE_W-1:0] r_drive;

    // Result register
    logic        [ecpmc_pkg::MOTOR_W-1:0] r_o_motor;
    logic signed [ecpmc_pkg::DRIVE_W-1:0] r_o_drive;
    logic                                 r_o_dvalid;
    logic signed [ecpmc_pkg::SPEED_W-1:0] r_o_speed;
    logic signed [ecpmc_pkg::POS_W-1:0]   r_o_pos;

    logic [EXT_W-1:0] motor_ext;
    logic [IDX_W-1:0] idx;
    logic             in_range;

    logic signed [DW-1:0]                 diff_raw, diff_wrap;
    logic signed [ecpmc_pkg::SPEED_W-1:0] delta;
    logic signed [ecpmc_pkg::POS_W-1:0]   total_next;

    logic signed [EW-1:0]                 mul_a;
    logic        [ecpmc_pkg::GAIN_W-1:0]  mul_b;
    logic signed [PW-1:0]                 mul_p;

    assign motor_ext = EXT_W'(r_motor);
    assign in_range  = int'(motor_ext) < MOTORS;
    assign idx       = motor_ext[IDX_W-1:0];

    // Count unwrap: fold the raw difference into [-32768, 32768]
    always_comb begin
        diff_raw = DW'(r_cnt) - DW'(r_prev[idx]);
        if (diff_raw > DW'(32768)) begin
            diff_wrap = diff_raw - DW'(65536);
        end else if (diff_raw < -DW'(32768)) begin
            diff_wrap = diff_raw + DW'(65536);
        end else begin
            diff_wrap = diff_raw;
        end
        delta      = ecpmc_pkg::SPEED_W'(diff_wrap);
        total_next = r_tot[idx] + ecpmc_pkg::POS_W'(delta);
    end

    // Shared multiplier: signed error or current times unsigned gain
    always_comb begin
        unique case (i_cmd.mul_sel)
            ecpmc_pkg::MUL_CUR_KT: begin
                mul_a = EW'(r_cur);
                mul_b = r_torque_kt;
            end
            ecpmc_pkg::MUL_ERR_TKP: begin
                mul_a = r_err;
                mul_b = r_torque_kp;
            end
            ecpmc_pkg::MUL_ERR_PKI: begin
                mul_a = r_err;
                mul_b = r_pos_ki_dt;
            end
            ecpmc_pkg::MUL_ERR_PKP: begin
                mul_a = r_err;
                mul_b = r_pos_kp;
            end
            ecpmc_pkg::MUL_ERR_SKI: begin
                mul_a = r_err;
                mul_b = r_speed_ki_dt;
            end
            ecpmc_pkg::MUL_ERR_SKP: begin
                mul_a = r_err;
                mul_b = r_speed_kp;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * $signed({1'b0, mul_b});
    end

    // Configuration and per-motor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_kp    <= '0;
            r_speed_ki_dt <= '0;
            r_speed_limit <= ecpmc_pkg::SPEED_LIMIT_RST;
            r_pos_kp      <= '0;
            r_pos_ki_dt   <= '0;
            r_pos_limit   <= '0;
            r_torque_kp   <= '0;
            r_torque_kt   <= '0;
            for (int k = 0; k < MOTORS; k++) begin
                r_prev[k]  <= '0;
                r_tot[k]   <= '0;
                r_s_int[k] <= '0;
                r_p_int[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (ecpmc_pkg::t_cfg_reg'(i_cfg_idx))
                    ecpmc_pkg::REG_SPEED_KP:    r_speed_kp    <= i_cfg_data;
                    ecpmc_pkg::REG_SPEED_KI_DT: r_speed_ki_dt <= i_cfg_data;
                    ecpmc_pkg::REG_SPEED_LIMIT:
                        r_speed_limit <= i_cfg_data[ecpmc_pkg::LIM_W-1:0];
                    ecpmc_pkg::REG_POS_KP:      r_pos_kp      <= i_cfg_data;
                    ecpmc_pkg::REG_POS_KI_DT:   r_pos_ki_dt   <= i_cfg_data;
                    ecpmc_pkg::REG_POS_LIMIT:
                        r_pos_limit <= i_cfg_data[ecpmc_pkg::LIM_W-1:0];
                    ecpmc_pkg::REG_TORQUE_KP:   r_torque_kp   <= i_cfg_data;
                    ecpmc_pkg::REG_TORQUE_KT:   r_torque_kt   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.unwrap && in_range) begin
                r_prev[idx] <= r_cnt;
                r_tot[idx]  <= total_next;
                if (!r_en) begin
                    r_s_int[idx] <= '0;
                    r_p_int[idx] <= '0;
                end
            end
            if (i_cmd.p_integ) begin
                r_p_int[idx] <= ecpmc_pkg::INTEG_W'(ecpmc_pkg::clamp_lim(
                    PW'(r_p_int[idx]) + r_prod, r_pos_limit));
            end
            if (i_cmd.s_integ) begin
                r_s_int[idx] <= ecpmc_pkg::INTEG_W'(ecpmc_pkg::clamp_lim(
                    PW'(r_s_int[idx]) + ecpmc_pkg::shr_tz(r_prod, ecpmc_pkg::FRAC_W),
                    r_speed_limit));
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_motor <= i_motor;
            r_cnt   <= i_encoder_count;
            r_cur   <= i_current_sample;
            r_en    <= i_enabled;
            r_mode  <= ecpmc_pkg::t_mode'(i_mode);
            r_sp    <= i_target;
        end
        if (i_cmd.unwrap) begin
            r_delta <= in_range ? delta : '0;
            r_total <= in_range ? total_next : '0;
            r_drive <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.t_err) begin
            r_err <= EW'(r_sp) - EW'(ecpmc_pkg::shr_tz(r_prod, ecpmc_pkg::TQ_SHIFT));
        end
        if (i_cmd.p_err) begin
            r_err <= EW'(r_sp) - EW'(r_total);
        end
        if (i_cmd.s_err) begin
            r_err <= EW'(r_sp) - (EW'(r_delta) <<< ecpmc_pkg::FRAC_W);
        end
        if (i_cmd.t_sat) begin
            r_drive <= ecpmc_pkg::sat_drive(
                ecpmc_pkg::shr_tz(r_prod, ecpmc_pkg::TQ_OUT_SHIFT));
        end
        if (i_cmd.p_cmd) begin
            r_sp <= ecpmc_pkg::TGT_W'(ecpmc_pkg::clamp_lim(
                r_prod + PW'(r_p_int[idx]), r_pos_limit));
        end
        if (i_cmd.s_out) begin
            r_drive <= ecpmc_pkg::DRIVE_W'(ecpmc_pkg::shr_tz(ecpmc_pkg::clamp_lim(
                ecpmc_pkg::shr_tz(r_prod, ecpmc_pkg::FRAC_W) + PW'(r_s_int[idx]),
                r_speed_limit), ecpmc_pkg::FRAC_W));
        end
        if (i_cmd.out_load) begin
            r_o_motor  <= r_motor;
            r_o_drive  <= r_drive;
            r_o_dvalid <= r_en && in_range;
            r_o_speed  <= r_delta;
            r_o_pos    <= r_total;
        end
    end

    assign o_status.in_range = in_range;
    assign o_status.enabled  = r_en;
    assign o_status.mode     = r_mode;

    assign o_motor_out   = r_o_motor;
    assign o_drive       = r_o_drive;
    assign o_drive_valid = r_o_dvalid;
    assign o_speed       = r_o_speed;
    assign o_position    = r_o_pos;

endmodule

`default_nettype wire

// ===== rtl/ecpmc_ctrl.sv =====
`default_nettype none

module ecpmc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    input  ecpmc_pkg::t_dp_status i_status,
    output ecpmc_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_UNWRAP = 15'b000000000000010,
        ST_T_MUL1 = 15'b000000000000100,
        ST_T_ERR  = 15'b000000000001000,
        ST_T_MUL2 = 15'b000000000010000,
        ST_T_SAT  = 15'b000000000100000,
        ST_P_ERR  = 15'b000000001000000,
        ST_P_MULI = 15'b000000010000000,
        ST_P_MULP = 15'b000000100000000,
        ST_P_CMD  = 15'b000001000000000,
        ST_S_ERR  = 15'b000010000000000,
        ST_S_MULI = 15'b000100000000000,
        ST_S_MULP = 15'b001000000000000,
        ST_S_OUT  = 15'b010000000000000,
        ST_DONE   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = ecpmc_pkg::MUL_CUR_KT;
        o_in_ready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_UNWRAP;
                end
            end
            ST_UNWRAP: begin
                o_cmd.unwrap = 1'b1;
                if (!i_status.in_range || !i_status.enabled) begin
                    n_state = ST_DONE;
                end else begin
                    unique case (i_status.mode)
                        ecpmc_pkg::MODE_TORQUE:   n_state = ST_T_MUL1;
                        ecpmc_pkg::MODE_SPEED:    n_state = ST_S_ERR;
                        ecpmc_pkg::MODE_POSITION: n_state = ST_P_ERR;
                        default:                  n_state = ST_DONE;
                    endcase
                end
            end
            ST_T_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = ecpmc_pkg::MUL_CUR_KT;
                n_state       = ST_T_ERR;
            end
            ST_T_ERR: begin
                o_cmd.t_err = 1'b1;
                n_state     = ST_T_MUL2;
            end
            ST_T_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = ecpmc_pkg::MUL_ERR_TKP;
                n_state       = ST_T_SAT;
            end
            ST_T_SAT: begin
                o_cmd.t_sat = 1'b1;
                n_state     = ST_DONE;
            end
            ST_P_ERR: begin
                o_cmd.p_err = 1'b1;
                n_state     = ST_P_MULI;
            end
            ST_P_MULI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = ecpmc_pkg::MUL_ERR_PKI;
                n_state       = ST_P_MULP;
            end
            ST_P_MULP: begin
                // integrate with the ki product while kp is multiplied
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = ecpmc_pkg::MUL_ERR_PKP;
                o_cmd.p_integ = 1'b1;
                n_state       = ST_P_CMD;
            end
            ST_P_CMD: begin
                o_cmd.p_cmd = 1'b1;
                n_state     = ST_S_ERR;
            end
            ST_S_ERR: begin
                o_cmd.s_err = 1'b1;
                n_state     = ST_S_MULI;
            end
            ST_S_MULI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = ecpmc_pkg::MUL_ERR_SKI;
                n_state       = ST_S_MULP;
            end
            ST_S_MULP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = ecpmc_pkg::MUL_ERR_SKP;
                o_cmd.s_integ = 1'b1;
                n_state       = ST_S_OUT;
            end
            ST_S_OUT: begin
                o_cmd.s_out = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/encoder_cascaded_pi_motor_ctrl_unit.sv =====
// Cascaded position/speed PI motor controller with encoder unwrap. Each request is one
// control tick of one motor: the 16-bit encoder count is unwrapped against the motor's
// previous count and added to its wrapping 32-bit position, and a drive value is formed
// by torque (proportional), speed (clamped PI) or position (PI into speed PI) control
// in Q16.16 with truncation toward zero. Requests are handled one at a time by a
// sequencer driving one shared 34x24-bit multiplier: disabled, out-of-range or mode 0
// requests go from unwrap to the result handoff; other modes run torque, speed PI or
// position-then-speed PI steps first. The handoff waits while the result register is
// full, and a finished result waits there while the next request is taken. The user
// must write gains on the plain write port only while idle; the block does not check.

`default_nettype none

module encoder_cascaded_pi_motor_ctrl_unit #(
    parameter int MOTORS = ecpmc_pkg::MOTORS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ecpmc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ecpmc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ecpmc_req_if.sink                           i_req,
    ecpmc_rsp_if.source                         o_rsp
);

    ecpmc_pkg::t_dp_cmd    cmd;
    ecpmc_pkg::t_dp_status status;
    logic                  in_ready;
    logic                  out_valid;

    // Sequencer: one state per datapath step, result handoff in the last state
    ecpmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: gains, per-motor state, shared multiplier and result register
    ecpmc_dp #(
        .MOTORS (MOTORS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_motor          (i_req.motor),
        .i_encoder_count  (i_req.encoder_count),
        .i_current_sample (i_req.current_sample),
        .i_enabled        (i_req.enabled),
        .i_mode           (i_req.mode),
        .i_target         (i_req.target),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_motor_out      (o_rsp.motor_out),
        .o_drive          (o_rsp.drive),
        .o_drive_valid    (o_rsp.drive_valid),
        .o_speed          (o_rsp.speed),
        .o_position       (o_rsp.position)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // Ready drops once a request is taken, while that request is in flight
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && in_ready) |=> !in_ready
    ) else $error("request accepted while previous one still in flight");

    // The result register is never overwritten while a result waits
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!out_valid || o_rsp.ready)
    ) else $error("result register overwritten before being taken");

    // No drive without control enabled
    a_drive_gated: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !o_rsp.drive_valid) |-> (o_rsp.drive == '0)
    ) else $error("drive nonzero while control disabled");

    // Motor index out of range gives an empty result
    a_out_of_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && (int'(o_rsp.motor_out) >= MOTORS)) |->
            (o_rsp.speed == '0 && o_rsp.position == '0 && !o_rsp.drive_valid)
    ) else $error("out-of-range motor produced tracking data");

endmodule

`default_nettype wire

// ===== dv/encoder_cascaded_pi_motor_ctrl_unit_tb.sv =====
`default_nettype none

// Checks the cascaded PI motor controller against a behavioral predictor of the control
// tick. A short table of directed requests (register extremes, delta wrap corners, every
// mode, disable clearing) runs first. Random request streams follow under six gain
// settings, with request gaps and result stalls varied per phase. Every result is
// compared field by field with the oldest predicted one.

module encoder_cascaded_pi_motor_ctrl_unit_tb;
    import ecpmc_pkg::*;

    localparam int MOTORS          = MOTORS_DEF;
    localparam int N_REGS          = 8;
    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 16;
    localparam int PHASES          = 6;
    localparam int TICKS_PER_PHASE = 335;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int DIR_ROWS        = 33;

    typedef struct packed {
        logic        [MOTOR_W-1:0] motor;
        logic signed [COUNT_W-1:0] count;
        logic signed [CUR_W-1:0]   current;
        logic                      enabled;
        t_mode                     mode;
        logic signed [TGT_W-1:0]   target;
    } tick_req_t;

    typedef struct packed {
        logic        [MOTOR_W-1:0] motor_out;
        logic signed [DRIVE_W-1:0] drive;
        logic                      drive_valid;
        logic signed [SPEED_W-1:0] speed;
        logic signed [POS_W-1:0]   position;
    } tick_rsp_t;

    // One table row: either a register write or a request; typed rows carry a
    // hand-computed result, the rest are checked against the predictor.
    typedef struct packed {
        logic            is_cfg;
        t_cfg_reg        reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        tick_req_t       req;
        logic            typed;
        tick_rsp_t       want;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_reg              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ecpmc_req_if req_if ();
    ecpmc_rsp_if rsp_if ();

    encoder_cascaded_pi_motor_ctrl_unit #(
        .MOTORS (MOTORS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // ------------------------------------------------------------------
    // Predictor state: gains and per-motor tracking / integrators
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] g_speed_kp, g_speed_ki, g_pos_kp, g_pos_ki, g_torque_kp, g_torque_kt;
    logic [LIM_W-1:0]  g_speed_limit, g_pos_limit;

    logic signed [COUNT_W-1:0] last_count     [MOTORS] = '{default: '0};
    int                        position_total [MOTORS] = '{default: 0};
    int                        speed_integ    [MOTORS] = '{default: 0};
    int                        pos_integ      [MOTORS] = '{default: 0};

    tick_rsp_t predicted_ticks [$];
    int        n_mismatch = 0;
    int        req_gap_pct = 0;
    int        rsp_stall_pct = 0;

    // Shift right, rounding toward zero
    function automatic longint trunc_shr(input longint v, input int n);
        if (v < 0) begin
            return -((-v) >>> n);
        end
        return v >>> n;
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Speed PI on a Q16.16 error; updates the motor's speed integrator
    function automatic longint speed_pi(input longint err, input int m);
        longint lim;
        longint acc;
        lim = longint'(g_speed_limit) <<< FRAC_W;
        acc = clamp_sym(longint'(speed_integ[m]) + trunc_shr(err * longint'(g_speed_ki), FRAC_W),
                        lim);
        speed_integ[m] = int'(acc);
        return clamp_sym(trunc_shr(err * longint'(g_speed_kp), FRAC_W) + acc, lim);
    endfunction

    // One control tick: unwrap, accumulate, drive
    function automatic tick_rsp_t control_tick(input tick_req_t t);
        tick_rsp_t o;
        int        m;
        longint    delta, drv, tgt, torque, perr, plim, pacc, cmd;
        o = '0;
        o.motor_out = t.motor;
        m = int'(t.motor);
        if (m >= MOTORS) begin
            return o;
        end
        tgt = longint'(t.target);
        delta = longint'(t.count) - longint'(last_count[m]);
        if (delta > 32768) begin
            delta = delta - 65536;
        end
        if (delta < -32768) begin
            delta = delta + 65536;
        end
        last_count[m] = t.count;
        position_total[m] = position_total[m] + int'(delta);
        drv = 0;
        if (!t.enabled) begin
            speed_integ[m] = 0;
            pos_integ[m] = 0;
        end else begin
            case (t.mode)
                MODE_TORQUE: begin
                    torque = trunc_shr(longint'(t.current) * longint'(g_torque_kt), TQ_SHIFT);
                    drv = trunc_shr((tgt - torque) * longint'(g_torque_kp), TQ_OUT_SHIFT);
                    if (drv > 32767) begin
                        drv = 32767;
                    end
                    if (drv < -32768) begin
                        drv = -32768;
                    end
                end
                MODE_SPEED: begin
                    drv = trunc_shr(speed_pi(tgt - delta * 65536, m), FRAC_W);
                end
                MODE_POSITION: begin
                    plim = longint'(g_pos_limit) <<< FRAC_W;
                    perr = tgt - longint'(position_total[m]);
                    pacc = clamp_sym(longint'(pos_integ[m]) + perr * longint'(g_pos_ki), plim);
                    pos_integ[m] = int'(pacc);
                    cmd = clamp_sym(perr * longint'(g_pos_kp) + pacc, plim);
                    drv = trunc_shr(speed_pi(cmd - delta * 65536, m), FRAC_W);
                end
                default: begin
                    drv = 0;
                end
            endcase
        end
        o.drive = drv[DRIVE_W-1:0];
        o.drive_valid = t.enabled;
        o.speed = delta[SPEED_W-1:0];
        o.position = position_total[m];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Typed results come straight from the arithmetic:
    // zero gains give zero drive, and max kt/kp with opposite-sign
    // target and current saturate the torque drive.
    // ------------------------------------------------------------------
    stim_row_t directed_rows [DIR_ROWS] = '{
        // after reset, disabled: nothing tracked yet
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, 16'sd0, 16'sd0, 1'b0, MODE_OFF, 32'sd0},
          1'b1, '{2'd0, 16'sd0, 1'b0, 17'sd0, 32'sd0}},
        // mode 0 while enabled: drive 0, drive_valid 1
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, 16'sd32767, 16'sd0, 1'b1, MODE_OFF, 32'sd0},
          1'b1, '{2'd0, 16'sd0, 1'b1, 17'sd32767, 32'sd32767}},
        // raw delta -65535 unwraps to +1
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, 16'sh8000, 16'sd1000, 1'b1, MODE_TORQUE,
          32'sh0001_0000}, 1'b1, '{2'd0, 16'sd0, 1'b1, 17'sd1, 32'sd32768}},
        // delta exactly -32768 stays
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd1, 16'sh8000, 16'sd0, 1'b0, MODE_SPEED, 32'sd0},
          1'b1, '{2'd1, 16'sd0, 1'b0, -17'sd32768, -32'sd32768}},
        // delta exactly +32768 stays
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd1, 16'sd0, 16'sd0, 1'b1, MODE_SPEED, 32'sd0},
          1'b1, '{2'd1, 16'sd0, 1'b1, 17'sd32768, 32'sd0}},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd2, 16'sd100, 16'sd0, 1'b1, MODE_POSITION, 32'sd0},
          1'b1, '{2'd2, 16'sd0, 1'b1, 17'sd100, 32'sd100}},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd3, 16'sd0, 16'sh8000, 1'b1, MODE_TORQUE,
          32'sh7fff_ffff}, 1'b1, '{2'd3, 16'sd0, 1'b1, 17'sd0, 32'sd0}},
        // gains for the rest of the table
        '{1'b1, REG_TORQUE_KP,   24'hFF_FFFF, '0, 1'b0, '0},
        '{1'b1, REG_TORQUE_KT,   24'hFF_FFFF, '0, 1'b0, '0},
        '{1'b1, REG_SPEED_KP,    24'h01_0000, '0, 1'b0, '0},
        '{1'b1, REG_SPEED_KI_DT, 24'h00_1000, '0, 1'b0, '0},
        '{1'b1, REG_SPEED_LIMIT, 24'd100,     '0, 1'b0, '0},
        '{1'b1, REG_POS_KP,      24'h00_8000, '0, 1'b0, '0},
        '{1'b1, REG_POS_KI_DT,   24'h00_0100, '0, 1'b0, '0},
        '{1'b1, REG_POS_LIMIT,   24'd50,      '0, 1'b0, '0},
        // torque saturation at both ends
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd3, 16'sd0, 16'sh8000, 1'b1, MODE_TORQUE,
          32'sh7fff_ffff}, 1'b1, '{2'd3, 16'sd32767, 1'b1, 17'sd0, 32'sd0}},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd3, 16'sd0, 16'sd32767, 1'b1, MODE_TORQUE,
          32'sh8000_0000}, 1'b1, '{2'd3, 16'sh8000, 1'b1, 17'sd0, 32'sd0}},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd3, 16'sd0, 16'sd0, 1'b1, MODE_TORQUE, 32'sd0},
          1'b1, '{2'd3, 16'sd0, 1'b1, 17'sd0, 32'sd0}},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd2, 16'sd100, 16'sd0, 1'b0, MODE_POSITION,
          32'sd5000}, 1'b1, '{2'd2, 16'sd0, 1'b0, 17'sd0, 32'sd100}},
        // speed PI: integrator builds, holds through mode 0, clears on disable
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, -16'sd32700, 16'sd0, 1'b1, MODE_SPEED,
          32'sh0005_0000}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, -16'sd32700, 16'sd0, 1'b1, MODE_SPEED,
          32'sh0005_0000}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, -16'sd32690, 16'sd0, 1'b1, MODE_OFF, 32'sd0},
          1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, -16'sd32690, 16'sd0, 1'b1, MODE_SPEED,
          32'sh0005_0000}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, -16'sd32690, 16'sd0, 1'b0, MODE_SPEED,
          32'sh0005_0000}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd0, -16'sd32690, 16'sd0, 1'b1, MODE_SPEED,
          32'sh0005_0000}, 1'b0, '0},
        // position cascade approaching, then reversing
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd2, 16'sd100, 16'sd0, 1'b1, MODE_POSITION,
          32'sd1000}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd2, 16'sd150, 16'sd0, 1'b1, MODE_POSITION,
          32'sd1000}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd2, 16'sd150, 16'sd0, 1'b1, MODE_POSITION,
          -32'sd1000}, 1'b0, '0},
        // extreme setpoints hit the limits
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd1, 16'sd0, 16'sd0, 1'b1, MODE_SPEED,
          32'sh7fff_ffff}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd1, 16'sd40, 16'sd0, 1'b1, MODE_SPEED,
          32'sh8000_0000}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd3, 16'sd32767, 16'sd256, 1'b1, MODE_POSITION,
          32'sh7fff_ffff}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd3, 16'sh8000, -16'sd1, 1'b1, MODE_POSITION,
          32'sh8000_0000}, 1'b0, '0},
        '{1'b0, REG_SPEED_KP, 24'h0, '{2'd1, 16'sd40, 16'sd256, 1'b1, MODE_TORQUE,
          32'sh0010_0000}, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, compare against oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_tick_result();
        tick_rsp_t want;
        if (predicted_ticks.size() == 0) begin
            $error("result with no request pending: motor_out %0d", rsp_if.motor_out);
            n_mismatch++;
            return;
        end
        want = predicted_ticks.pop_front();
        if (rsp_if.motor_out !== want.motor_out) begin
            $error("motor_out: expected %0d, got %0d", want.motor_out, rsp_if.motor_out);
            n_mismatch++;
        end
        if (rsp_if.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, rsp_if.drive);
            n_mismatch++;
        end
        if (rsp_if.drive_valid !== want.drive_valid) begin
            $error("drive_valid: expected %0d, got %0d", want.drive_valid, rsp_if.drive_valid);
            n_mismatch++;
        end
        if (rsp_if.speed !== want.speed) begin
            $error("speed: expected %0d, got %0d", want.speed, rsp_if.speed);
            n_mismatch++;
        end
        if (rsp_if.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp_if.position);
            n_mismatch++;
        end
    endfunction

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                check_tick_result();
            end
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Register write; predictor copy follows the same masking as the block
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_SPEED_KP:    g_speed_kp    = val[GAIN_W-1:0];
            REG_SPEED_KI_DT: g_speed_ki    = val[GAIN_W-1:0];
            REG_SPEED_LIMIT: g_speed_limit = val[LIM_W-1:0];
            REG_POS_KP:      g_pos_kp      = val[GAIN_W-1:0];
            REG_POS_KI_DT:   g_pos_ki      = val[GAIN_W-1:0];
            REG_POS_LIMIT:   g_pos_limit   = val[LIM_W-1:0];
            REG_TORQUE_KP:   g_torque_kp   = val[GAIN_W-1:0];
            REG_TORQUE_KT:   g_torque_kt   = val[GAIN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drop valid and let every outstanding result come back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (predicted_ticks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // kind 0: all max, 3: all zero, 4: full random, others: moderate gains
    task automatic load_gains(input int kind);
        logic [CFG_DATA_W-1:0] val [N_REGS];
        for (int i = 0; i < N_REGS; i++) begin
            case (kind)
                0:       val[i] = 24'hFF_FFFF;
                3:       val[i] = '0;
                4:       val[i] = CFG_DATA_W'($urandom);
                default: val[i] = CFG_DATA_W'($urandom_range(24'h04_0000));
            endcase
        end
        if (kind != 0 && kind != 3 && kind != 4) begin
            val[REG_SPEED_LIMIT] = ($urandom_range(3) == 0) ? 24'h00_7FFF
                                                             : CFG_DATA_W'($urandom_range(1, 2000));
            val[REG_POS_LIMIT]   = ($urandom_range(3) == 0) ? 24'h00_7FFF
                                                             : CFG_DATA_W'($urandom_range(1, 500));
        end
        for (int i = 0; i < N_REGS; i++) begin
            write_reg(t_cfg_reg'(i), val[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Present one request, wait for acceptance, queue its prediction
    task automatic send_tick(input tick_req_t t, input logic typed, input tick_rsp_t want);
        int        gap;
        tick_rsp_t pred;
        gap = 0;
        while ($urandom_range(99) < req_gap_pct) gap++;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.motor          <= t.motor;
        req_if.encoder_count  <= t.count;
        req_if.current_sample <= t.current;
        req_if.enabled        <= t.enabled;
        req_if.mode           <= t.mode;
        req_if.target         <= t.target;
        do @(posedge i_clk); while (!req_if.ready);
        pred = control_tick(t);
        predicted_ticks.push_back(typed ? want : pred);
    endtask

    // Mostly plausible motion: small count steps, targets near the current
    // state; a share of big jumps, half-turn flips and raw values as noise.
    function automatic tick_req_t random_tick();
        tick_req_t   t;
        int unsigned m;
        int unsigned pick;
        int          step;
        int          aim;
        m = $urandom_range(MOTORS - 1);
        t.motor = m[MOTOR_W-1:0];
        pick = $urandom_range(99);
        step = (pick < 70) ? int'($urandom_range(600)) - 300
                           : int'($urandom_range(65535)) - 32768;
        if (pick < 85) begin
            t.count = last_count[m] + COUNT_W'(step);
        end else if (pick < 90) begin
            t.count = last_count[m] ^ 16'h8000;   // delta of exactly half a turn
        end else begin
            t.count = COUNT_W'($urandom);
        end
        t.current = CUR_W'($urandom);
        t.enabled = ($urandom_range(99) < 90);
        t.mode = t_mode'($urandom_range(3));
        case (t.mode)
            MODE_TORQUE:   aim = int'($urandom_range(2 ** 21)) - 2 ** 20;
            MODE_SPEED:    aim = (int'($urandom_range(600)) - 300) * 65536
                                 + int'($urandom_range(65535));
            MODE_POSITION: aim = position_total[m] + int'($urandom_range(4000)) - 2000;
            default:       aim = int'($urandom);
        endcase
        if ($urandom_range(9) == 0) begin
            aim = int'($urandom);
        end
        t.target = aim;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        g_speed_kp    = '0;
        g_speed_ki    = '0;
        g_speed_limit = SPEED_LIMIT_RST;
        g_pos_kp      = '0;
        g_pos_ki      = '0;
        g_pos_limit   = '0;
        g_torque_kp   = '0;
        g_torque_kt   = '0;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= REG_SPEED_KP;
        i_cfg_data            <= '0;
        req_if.valid          <= 1'b0;
        req_if.motor          <= '0;
        req_if.encoder_count  <= '0;
        req_if.current_sample <= '0;
        req_if.enabled        <= 1'b0;
        req_if.mode           <= MODE_OFF;
        req_if.target         <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, mild idling on both sides
        req_gap_pct   = 18;
        rsp_stall_pct = 51;
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (directed_rows[k].is_cfg) begin
                // registers only change with the block idle
                if (k == 0 || !directed_rows[k - 1].is_cfg) begin
                    drain();
                end
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
                if (k == DIR_ROWS - 1 || !directed_rows[k + 1].is_cfg) begin
                    i_cfg_we <= 1'b0;
                end
            end else begin
                send_tick(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
            end
        end

        // random phases: pairs of gain settings per idling profile
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            load_gains(ph);
            case (ph / 2)
                0: begin
                    req_gap_pct   = 18;
                    rsp_stall_pct = 51;
                end
                1: begin
                    req_gap_pct   = 51;
                    rsp_stall_pct = 18;
                end
                default: begin
                    req_gap_pct   = 0;
                    rsp_stall_pct = 0;
                end
            endcase
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                // hold requests mid-phase until the pipeline is empty
                if (ph == 1 && k == TICKS_PER_PHASE / 2) begin
                    drain();
                end
                send_tick(random_tick(), 1'b0, '0);
            end
        end

        drain();
        if (n_mismatch == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/ecpmc_pkg.sv
rtl/ecpmc_req_if.sv
rtl/ecpmc_rsp_if.sv
rtl/ecpmc_dp.sv
rtl/ecpmc_ctrl.sv
rtl/encoder_cascaded_pi_motor_ctrl_unit.sv
dv/encoder_cascaded_pi_motor_ctrl_unit_tb.sv
